@@ design/pulse_peak_and_edge_timing_core_macros.svh @@
// Assertion macros shared by the pulse peak and edge timing core modules.
`ifndef PULSE_PEAK_AND_EDGE_TIMING_CORE_MACROS_SVH
`define PULSE_PEAK_AND_EDGE_TIMING_CORE_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define PPTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define PPTC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

@@ design/pptc_pkg.sv @@
// Shared constants, types and level tables of the pulse peak and edge timing core.
package pptc_pkg;

  // Store geometry and field widths.
  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned NUM_BANKS   = 2;
  localparam int unsigned BANK_W      = $clog2(NUM_BANKS);
  localparam int unsigned ADDR_W      = BANK_W + IDX_W;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned DIST_W      = SAMPLE_W + FRAC_W;
  localparam int unsigned MAX_DIST_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [MAX_DIST_W-1:0] MAX_DIST_RESET = MAX_DIST_W'(10000);

  // Level slots, in result order.
  localparam int unsigned NUM_LEVELS = 6;
  localparam int unsigned LVL_W      = $clog2(NUM_LEVELS);

  localparam logic [LVL_W-1:0] LVL_HALF_RISE = LVL_W'(0);
  localparam logic [LVL_W-1:0] LVL_HALF_FALL = LVL_W'(1);
  localparam logic [LVL_W-1:0] LVL_RISE10    = LVL_W'(2);
  localparam logic [LVL_W-1:0] LVL_RISE90    = LVL_W'(3);
  localparam logic [LVL_W-1:0] LVL_RISE5     = LVL_W'(4);
  localparam logic [LVL_W-1:0] LVL_RISE95    = LVL_W'(5);

  // Only the half level on the falling edge searches after the peak.
  localparam logic [NUM_LEVELS-1:0] LEVEL_AFTER = NUM_LEVELS'(1) << LVL_HALF_FALL;

  // Level fractions as unsigned 0.16 fixed point.
  function automatic logic [FRAC_W-1:0] level_frac(input logic [LVL_W-1:0] lvl);
    logic [FRAC_W-1:0] frac;
    unique case (lvl) inside
      LVL_HALF_RISE, LVL_HALF_FALL: frac = FRAC_W'(32768);
      LVL_RISE10:                   frac = FRAC_W'(6554);
      LVL_RISE90:                   frac = FRAC_W'(58982);
      LVL_RISE5:                    frac = FRAC_W'(3277);
      LVL_RISE95:                   frac = FRAC_W'(62259);
      default:                      frac = '0;
    endcase
    return frac;
  endfunction

  // One finished waveform, handed from the front to the back.
  typedef struct packed {
    logic [BANK_W-1:0]   bank;
    logic [CNT_W-1:0]    count;
    logic [SAMPLE_W-1:0] peak_value;
    logic [IDX_W-1:0]    peak_index;
    logic                dropped;
  } job_t;

  // Sample store write port.
  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] data;
  } store_wr_t;

  // Bank release from the back once a search is finished.
  typedef struct packed {
    logic              valid;
    logic [BANK_W-1:0] bank;
  } bank_release_t;

endpackage

@@ design/pulse_peak_and_edge_timing_core.sv @@
// Top level of the pulse peak and edge timing core.
//
// Samples enter on the in channel (valid/ready), one per item; an item with
// last_sample_i set closes the waveform. The front writes samples into one
// bank of a two-bank store while the back searches the other bank, so a new
// waveform can stream in while the previous one is measured.
// The front takes one item per cycle as long as its current bank is free.
// After the last sample, the back takes the job, forms the six level products
// one at a time on one shared multiplier, reads the N samples of an N-sample
// waveform from the store at one per cycle, drains the read and distance
// pipeline and loads the result register once that register is free. The
// single store read port sets the pace of the walk.
// One result item per waveform leaves on the out channel (valid/ready); it
// waits in an output register, so a stalled receiver only blocks the back
// once it has finished the next waveform, and the front once both banks
// hold waveforms. The cfg channel writes max_distance and is always ready.
// Reset empties both banks' bookkeeping, the job queue and the result
// register, and sets max_distance to 10000; store contents are not cleared.
module pulse_peak_and_edge_timing_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [15:0]                     sample_value_i,
  input  logic                            last_sample_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pptc_pkg::MAX_DIST_W-1:0] cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            peak_found_o,
  output logic [pptc_pkg::IDX_W-1:0]      peak_index_o,
  output logic [pptc_pkg::SAMPLE_W-1:0]   peak_value_o,
  output logic [pptc_pkg::IDX_W-1:0]      half_rise_index_o,
  output logic [pptc_pkg::IDX_W-1:0]      half_fall_index_o,
  output logic [pptc_pkg::IDX_W-1:0]      rise10_index_o,
  output logic [pptc_pkg::IDX_W-1:0]      rise90_index_o,
  output logic [pptc_pkg::IDX_W-1:0]      rise5_index_o,
  output logic [pptc_pkg::IDX_W-1:0]      rise95_index_o,
  output logic                            overflow_o
);

  pptc_pkg::store_wr_t             wr;
  pptc_pkg::bank_release_t         rel;
  pptc_pkg::job_t                  push_job, head_job;
  logic                            push, pop, q_full, q_empty;
  logic [pptc_pkg::MAX_DIST_W-1:0] max_distance;
  logic [pptc_pkg::ADDR_W-1:0]     rd_addr;
  logic [pptc_pkg::SAMPLE_W-1:0]   rd_data;

  // Sample intake and peak tracking.
  pptc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_value_i (sample_value_i),
    .last_sample_i  (last_sample_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .max_distance_o (max_distance),
    .wr_o           (wr),
    .push_o         (push),
    .job_o          (push_job),
    .q_full_i       (q_full),
    .rel_i          (rel)
  );

  // Two-bank sample store.
  pptc_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Finished waveforms waiting for the back.
  pptc_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (q_empty)
  );

  // Level search and result formation.
  pptc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .job_i             (head_job),
    .pop_o             (pop),
    .max_distance_i    (max_distance),
    .rd_addr_o         (rd_addr),
    .rd_data_i         (rd_data),
    .rel_o             (rel),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .peak_found_o      (peak_found_o),
    .peak_index_o      (peak_index_o),
    .peak_value_o      (peak_value_o),
    .half_rise_index_o (half_rise_index_o),
    .half_fall_index_o (half_fall_index_o),
    .rise10_index_o    (rise10_index_o),
    .rise90_index_o    (rise90_index_o),
    .rise5_index_o     (rise5_index_o),
    .rise95_index_o    (rise95_index_o),
    .overflow_o        (overflow_o)
  );

endmodule

@@ design/pptc_store.sv @@
// Two-bank sample store with one write port and one registered read port.
module pptc_store (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pptc_pkg::store_wr_t              wr_i,
  input  logic [pptc_pkg::ADDR_W-1:0]      rd_addr_i,
  output logic [pptc_pkg::SAMPLE_W-1:0]    rd_data_o
);

  logic [pptc_pkg::SAMPLE_W-1:0] mem_q [pptc_pkg::NUM_BANKS * pptc_pkg::DEPTH];
  logic [pptc_pkg::SAMPLE_W-1:0] rd_data_q;

  // Write side, driven by the front.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Read side, driven by the back; data arrives in the cycle after the address.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

  // The store holds no control state, so reset is not used.
  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

@@ design/pptc_front.sv @@
// Front end: accepts samples, fills a store bank, tracks the peak and hands off jobs.
`include "pulse_peak_and_edge_timing_core_macros.svh"

module pptc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Sample channel.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [15:0]                       sample_value_i,
  input  logic                              last_sample_i,
  // Configuration channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pptc_pkg::MAX_DIST_W-1:0]   cfg_data_i,
  output logic [pptc_pkg::MAX_DIST_W-1:0]   max_distance_o,
  // Store write port.
  output pptc_pkg::store_wr_t               wr_o,
  // Job queue push side.
  output logic                              push_o,
  output pptc_pkg::job_t                    job_o,
  input  logic                              q_full_i,
  // Bank release from the back.
  input  pptc_pkg::bank_release_t           rel_i
);

  logic [pptc_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [pptc_pkg::SAMPLE_W-1:0]   pk_val_q, pk_val_d;
  logic [pptc_pkg::IDX_W-1:0]      pk_idx_q, pk_idx_d;
  logic                            drop_q, drop_d;
  logic [pptc_pkg::BANK_W-1:0]     bank_q, bank_d;
  logic [pptc_pkg::NUM_BANKS-1:0]  busy_q, busy_d;
  logic [pptc_pkg::MAX_DIST_W-1:0] max_dist_q, max_dist_d;

  logic                            accept;
  logic                            has_room;
  logic [pptc_pkg::SAMPLE_W-1:0]   sample;

  assign sample   = sample_value_i[pptc_pkg::SAMPLE_W-1:0];
  assign has_room = cnt_q < pptc_pkg::CNT_W'(pptc_pkg::DEPTH);

  // An item is taken only into a bank the back is not reading.
  assign in_ready_o = !busy_q[bank_q] && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign cfg_ready_o    = 1'b1;
  assign max_distance_o = max_dist_q;

  // Store write of the incoming sample, if there is room.
  assign wr_o.en   = accept && has_room;
  assign wr_o.addr = {bank_q, cnt_q[pptc_pkg::IDX_W-1:0]};
  assign wr_o.data = sample;

  // Running waveform state and hand-off on the last sample.
  always_comb begin
    cnt_d      = cnt_q;
    pk_val_d   = pk_val_q;
    pk_idx_d   = pk_idx_q;
    drop_d     = drop_q;
    bank_d     = bank_q;
    busy_d     = busy_q;
    max_dist_d = max_dist_q;
    push_o     = 1'b0;

    if (cfg_valid_i) begin
      max_dist_d = cfg_data_i;
    end

    if (accept) begin
      if (has_room) begin
        cnt_d = cnt_q + pptc_pkg::CNT_W'(1);
        if (sample > pk_val_q) begin
          pk_val_d = sample;
          pk_idx_d = cnt_q[pptc_pkg::IDX_W-1:0];
        end
      end else begin
        drop_d = 1'b1;
      end
    end

    job_o.bank       = bank_q;
    job_o.count      = cnt_d;
    job_o.peak_value = pk_val_d;
    job_o.peak_index = pk_idx_d;
    job_o.dropped    = drop_d;

    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if (accept && last_sample_i) begin
      push_o         = 1'b1;
      busy_d[bank_q] = 1'b1;
      bank_d         = bank_q + pptc_pkg::BANK_W'(1);
      cnt_d          = '0;
      pk_val_d       = '0;
      pk_idx_d       = '0;
      drop_d         = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      pk_val_q   <= '0;
      pk_idx_q   <= '0;
      drop_q     <= 1'b0;
      bank_q     <= '0;
      busy_q     <= '0;
      max_dist_q <= pptc_pkg::MAX_DIST_RESET;
    end else begin
      cnt_q      <= cnt_d;
      pk_val_q   <= pk_val_d;
      pk_idx_q   <= pk_idx_d;
      drop_q     <= drop_d;
      bank_q     <= bank_d;
      busy_q     <= busy_d;
      max_dist_q <= max_dist_d;
    end
  end

  // The back only ever frees a bank that holds a job.
  `PPTC_ASSERT(a_release_of_busy_bank, rel_i.valid |-> busy_q[rel_i.bank],
               "bank released while not busy")

endmodule

@@ design/pptc_job_queue.sv @@
// Short queue of finished waveforms between the front and the back.
`include "pulse_peak_and_edge_timing_core_macros.svh"

module pptc_job_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pptc_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output pptc_pkg::job_t job_o,
  output logic           empty_o
);

  localparam int unsigned PTR_W = (pptc_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(pptc_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(pptc_pkg::QUEUE_DEPTH + 1);

  pptc_pkg::job_t    entries_q [pptc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(pptc_pkg::QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  assign full_o  = cnt_q == QCNT_W'(pptc_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign job_o   = entries_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  // The front must hold off when the queue is full, the back when it is empty.
  `PPTC_ASSERT_NEVER(a_push_when_full, push_i && full_o, "push into a full job queue")
  `PPTC_ASSERT_NEVER(a_pop_when_empty, pop_i && empty_o, "pop from an empty job queue")

endmodule

@@ design/pptc_back.sv @@
// Back end: computes level targets, walks a stored waveform and forms the result item.
`include "pulse_peak_and_edge_timing_core_macros.svh"

module pptc_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Job queue pop side.
  input  logic                              q_empty_i,
  input  pptc_pkg::job_t                    job_i,
  output logic                              pop_o,
  input  logic [pptc_pkg::MAX_DIST_W-1:0]   max_distance_i,
  // Store read port.
  output logic [pptc_pkg::ADDR_W-1:0]       rd_addr_o,
  input  logic [pptc_pkg::SAMPLE_W-1:0]     rd_data_i,
  // Bank release to the front.
  output pptc_pkg::bank_release_t           rel_o,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              peak_found_o,
  output logic [pptc_pkg::IDX_W-1:0]        peak_index_o,
  output logic [pptc_pkg::SAMPLE_W-1:0]     peak_value_o,
  output logic [pptc_pkg::IDX_W-1:0]        half_rise_index_o,
  output logic [pptc_pkg::IDX_W-1:0]        half_fall_index_o,
  output logic [pptc_pkg::IDX_W-1:0]        rise10_index_o,
  output logic [pptc_pkg::IDX_W-1:0]        rise90_index_o,
  output logic [pptc_pkg::IDX_W-1:0]        rise5_index_o,
  output logic [pptc_pkg::IDX_W-1:0]        rise95_index_o,
  output logic                              overflow_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MULT  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } bk_state_e;

  bk_state_e state_q, state_d;

  pptc_pkg::job_t                job_q;
  logic [pptc_pkg::DIST_W-1:0]   limit_q;
  logic [pptc_pkg::LVL_W-1:0]    lvl_q;
  logic [pptc_pkg::CNT_W-1:0]    scan_q;
  logic [pptc_pkg::DIST_W-1:0]   tgt_q [pptc_pkg::NUM_LEVELS];

  // Read and distance pipeline.
  logic                          rd_vld_q;
  logic [pptc_pkg::IDX_W-1:0]    rd_idx_q;
  logic                          dist_vld_q;
  logic [pptc_pkg::DIST_W-1:0]   dist_q [pptc_pkg::NUM_LEVELS];
  logic [pptc_pkg::IDX_W-1:0]    dist_idx_q;
  logic                          before_q, after_q;

  logic [pptc_pkg::DIST_W-1:0]   best_dist_q [pptc_pkg::NUM_LEVELS];
  logic [pptc_pkg::IDX_W-1:0]    best_pos_q [pptc_pkg::NUM_LEVELS];

  logic                          out_vld_q;
  logic                          issue;
  logic                          load_out;
  logic                          found;
  logic                          last_issue;
  logic [pptc_pkg::DIST_W-1:0]   sample_ext;
  logic [pptc_pkg::DIST_W-1:0]   prod;

  assign found      = job_q.peak_value != '0;
  assign issue      = state_q == ST_SCAN;
  assign last_issue = pptc_pkg::CNT_W'(scan_q + pptc_pkg::CNT_W'(1)) == job_q.count;
  assign rd_addr_o  = {job_q.bank, scan_q[pptc_pkg::IDX_W-1:0]};
  assign sample_ext = {rd_data_i, pptc_pkg::FRAC_W'(0)};
  assign prod       = pptc_pkg::DIST_W'(job_q.peak_value) *
                      pptc_pkg::DIST_W'(pptc_pkg::level_frac(lvl_q));

  // Sequencer: take a job, compute targets, walk the bank, drain, hand off.
  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          state_d = ST_MULT;
        end
      end
      ST_MULT: begin
        if (lvl_q == pptc_pkg::LVL_W'(pptc_pkg::NUM_LEVELS - 1)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !dist_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rel_o.valid = load_out;
  assign rel_o.bank  = job_q.bank;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      lvl_q      <= '0;
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      dist_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= issue;
      dist_vld_q <= rd_vld_q;
      if (pop_o) begin
        lvl_q  <= '0;
        scan_q <= '0;
      end else begin
        if (state_q == ST_MULT) begin
          lvl_q <= lvl_q + pptc_pkg::LVL_W'(1);
        end
        if (issue) begin
          scan_q <= scan_q + pptc_pkg::CNT_W'(1);
        end
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Job capture, target products and the read/distance pipeline payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q   <= job_i;
      limit_q <= {max_distance_i, pptc_pkg::FRAC_W'(0)};
    end
    if (state_q == ST_MULT) begin
      tgt_q[lvl_q] <= prod;
    end
    rd_idx_q   <= scan_q[pptc_pkg::IDX_W-1:0];
    dist_idx_q <= rd_idx_q;
    before_q   <= found && (rd_idx_q < job_q.peak_index);
    after_q    <= !found || (rd_idx_q > job_q.peak_index);
    for (int k = 0; k < pptc_pkg::NUM_LEVELS; k++) begin
      dist_q[k] <= (tgt_q[k] > sample_ext) ? tgt_q[k] - sample_ext
                                           : sample_ext - tgt_q[k];
    end
  end

  // Running best match per level; the first strict minimum wins.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < pptc_pkg::NUM_LEVELS; k++) begin
      if (pop_o) begin
        best_dist_q[k] <= {max_distance_i, pptc_pkg::FRAC_W'(0)};
        best_pos_q[k]  <= '0;
      end else if (dist_vld_q &&
                   (pptc_pkg::LEVEL_AFTER[k] ? after_q : before_q) &&
                   (dist_q[k] < best_dist_q[k])) begin
        best_dist_q[k] <= dist_q[k];
        best_pos_q[k]  <= dist_idx_q;
      end
    end
  end

  // Result register; frees the back while the item waits to be taken.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      peak_found_o      <= found;
      peak_index_o      <= job_q.peak_index;
      peak_value_o      <= job_q.peak_value;
      half_rise_index_o <= best_pos_q[pptc_pkg::LVL_HALF_RISE];
      half_fall_index_o <= best_pos_q[pptc_pkg::LVL_HALF_FALL];
      rise10_index_o    <= best_pos_q[pptc_pkg::LVL_RISE10];
      rise90_index_o    <= best_pos_q[pptc_pkg::LVL_RISE90];
      rise5_index_o     <= best_pos_q[pptc_pkg::LVL_RISE5];
      rise95_index_o    <= best_pos_q[pptc_pkg::LVL_RISE95];
      overflow_o        <= job_q.dropped;
    end
  end

  assign out_valid_o = out_vld_q;

  // The read pipeline is empty whenever no job is in hand.
  `PPTC_ASSERT(a_pipe_empty_in_idle, (state_q == ST_IDLE) |-> (!rd_vld_q && !dist_vld_q),
               "search pipeline busy while idle")
  // The best half-rise distance never rises above the snapshot limit during a search.
  `PPTC_ASSERT(a_best_within_limit,
               (state_q == ST_SCAN || state_q == ST_DRAIN) |->
               (best_dist_q[pptc_pkg::LVL_HALF_RISE] <= limit_q),
               "best distance above limit")

endmodule
